// File: hw/rtl/mfdl_pkg.sv
// Package for the modulated fractional delay line.
// Holds shared constants, widths and the sequencer state type; no dependencies.
package mfdl_pkg;

   // Default store depth and interpolation fraction width
   localparam int MFDL_STORE_DEPTH   = 131072;
   localparam int MFDL_FRACTION_BITS = 8;

   // Fixed field widths
   localparam int SAMPLE_W = 16;
   localparam int BASE_W   = 25;

   // Base delay after reset: 44100.0 samples with 8 fraction bits
   localparam logic [BASE_W-1:0] BASE_DELAY_RESET = 25'd11289600;

   // Sequencer steps for one item
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_FETCH,
      ST_BLEND,
      ST_EMIT
   } state_type;

endpackage

// File: hw/rtl/mfdl_store.sv
// Sample history store: one write port and two registered read ports.
// Depends on mfdl_pkg for the sample width.
module mfdl_store
   import mfdl_pkg::*;
#(
   parameter int DEPTH = MFDL_STORE_DEPTH,
   parameter int AW    = $clog2(MFDL_STORE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output logic [SAMPLE_W-1:0] rd_data_a,
   output logic [SAMPLE_W-1:0] rd_data_b
);

   logic [SAMPLE_W-1:0] store_ff [DEPTH];

   // Write the new sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read both taps into registered outputs
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= store_ff[rd_addr_a];
         rd_data_b <= store_ff[rd_addr_b];
      end
   end

endmodule

// File: hw/rtl/modulated_fractional_delay_line_core.sv
// Modulated fractional delay line, top level.
// Depends on mfdl_pkg and mfdl_store.
//
// Each accepted item writes its sample into a circular history of STORE_DEPTH entries and
// returns one sample read back at a delay of base_delay * (mod_in + 32768) / 65536,
// blended linearly between the two neighbouring history entries, rounded half up and
// saturated. The base delay has FRACTION_BITS fraction bits; the scaled delay is clamped
// just below STORE_DEPTH - 1 samples. An item reaches the output register through the
// steps scale with store write, two-tap store read, blend and round. A new item is taken
// only when the sequencer, stepping through the single history memory, is back in idle.
// There is no clearing pass after reset: a wrap flag and the write pointer tell which
// entries have been written, and history never written reads as zero.
module modulated_fractional_delay_line_core
   import mfdl_pkg::*;
#(
   parameter int STORE_DEPTH   = MFDL_STORE_DEPTH,
   parameter int FRACTION_BITS = MFDL_FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   // input items
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [15:0] sample_in, [31:16] mod_in
   // result items
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [15:0] sample_out
   // base delay register
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BASE_W-1:0] csr_wdata    // base_delay_q8
);

   localparam int PW   = $clog2(STORE_DEPTH);
   localparam int FB   = FRACTION_BITS;
   localparam int CW   = (PW + FB > BASE_W) ? PW + FB : BASE_W;
   localparam int PW_X = PW + 1;
   localparam int ACW  = SAMPLE_W + FB + 3;

   localparam logic [CW-1:0]         DELAY_MAX =
      CW'((longint'(STORE_DEPTH) - 1) * (longint'(1) << FB) - 1);
   localparam logic [PW_X-1:0]       DEPTH_X   = PW_X'(STORE_DEPTH);
   localparam logic [PW-1:0]         LAST_PTR  = PW'(STORE_DEPTH - 1);
   localparam logic signed [ACW-1:0] HALF_LSB  = ACW'(longint'(1) << (FB - 1));
   localparam logic signed [ACW-1:0] OUT_MAX   = ACW'(32767);
   localparam logic signed [ACW-1:0] OUT_MIN   = ACW'(-32768);

   state_type state_ff, state_in;

   logic [BASE_W-1:0]   base_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] mod_ff;
   logic [BASE_W-1:0]   delay_ff, delay_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic                wrapped_ff, wrapped_in;
   logic [FB-1:0]       frac_ff;
   logic                valid_a_ff, valid_b_ff;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic                req_fire;
   logic                store_wr, store_rd;
   logic [SAMPLE_W-1:0] rd_a, rd_b;

   // Delay and tap address logic
   logic [CW-1:0]       delay_sat;
   logic [PW-1:0]       back_n;
   logic [PW_X-1:0]     back_a, back_b, wp_x, ia_x, ib_x;
   logic [PW-1:0]       ia, ib;
   logic [SAMPLE_W:0]   mod_off;
   logic [BASE_W+SAMPLE_W:0] scaled;

   // Blend and round logic
   logic signed [SAMPLE_W-1:0] tap_a, tap_b;
   logic signed [SAMPLE_W:0]   tap_diff;
   logic signed [SAMPLE_W+FB+1:0] diff_prod;
   logic signed [ACW-1:0]     biased, rounded;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and store strobes
   always_comb begin
      state_in = state_ff;
      store_wr = 1'b0;
      store_rd = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            store_wr = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            store_rd = 1'b1;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Base delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         base_ff <= csr_wdata;
      end
   end

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_tdata[15:0];
         mod_ff    <= req_tdata[31:16];
      end
   end

   // Scale the base delay by the modulation factor
   assign mod_off  = {1'b0, ~mod_ff[SAMPLE_W-1], mod_ff[SAMPLE_W-2:0]};
   assign scaled   = {1'b0, base_ff} * {{BASE_W{1'b0}}, mod_off};
   assign delay_in = scaled[BASE_W+SAMPLE_W-1:SAMPLE_W];

   always_ff @(posedge clock) begin
      if (state_ff == ST_SCALE) begin
         delay_ff <= delay_in;
      end
   end

   // Clamp the delay and form both tap addresses
   always_comb begin
      delay_sat = CW'(delay_ff);
      if (delay_sat > DELAY_MAX) begin
         delay_sat = DELAY_MAX;
      end
      back_n = PW'(delay_sat >> FB);
      back_a = {1'b0, back_n};
      back_b = back_a + PW_X'(1);
      wp_x   = {1'b0, wp_ff};
      ia_x   = (wp_x >= back_a) ? (wp_x - back_a) : (wp_x + DEPTH_X - back_a);
      ib_x   = (wp_x >= back_b) ? (wp_x - back_b) : (wp_x + DEPTH_X - back_b);
      ia     = ia_x[PW-1:0];
      ib     = ib_x[PW-1:0];
   end

   // Hold the fraction and mark taps that were never written
   always_ff @(posedge clock) begin
      if (state_ff == ST_FETCH) begin
         frac_ff    <= delay_sat[FB-1:0];
         valid_a_ff <= wrapped_ff || (ia <= wp_ff);
         valid_b_ff <= wrapped_ff || (ib <= wp_ff);
      end
   end

   // Advance the write pointer once the taps are read
   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (state_ff == ST_FETCH) begin
         if (wp_ff == LAST_PTR) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   // History store
   mfdl_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (PW)
   ) u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (wp_ff),
      .wr_data   (sample_ff),
      .rd_en     (store_rd),
      .rd_addr_a (ia),
      .rd_addr_b (ib),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // Blend: a*W + (b - a)*f
   assign tap_a     = valid_a_ff ? $signed(rd_a) : '0;
   assign tap_b     = valid_b_ff ? $signed(rd_b) : '0;
   assign tap_diff  = (SAMPLE_W+1)'(tap_b) - (SAMPLE_W+1)'(tap_a);
   assign diff_prod = tap_diff * $signed({1'b0, frac_ff});
   assign acc_in    = (ACW'(tap_a) <<< FB) + ACW'(diff_prod);

   always_ff @(posedge clock) begin
      if (state_ff == ST_BLEND) begin
         acc_ff <= acc_in;
      end
   end

   // Round half up and saturate
   always_comb begin
      biased  = acc_ff + HALF_LSB;
      rounded = biased >>> FB;
      if (rounded > OUT_MAX) begin
         rsp_data_in = 16'h7FFF;
      end else if (rounded < OUT_MIN) begin
         rsp_data_in = 16'h8000;
      end else begin
         rsp_data_in = rounded[SAMPLE_W-1:0];
      end
   end

   // Output register: load on the round step, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: hw/rtl/mfdl_checker.sv
// Port-level checks for the modulated fractional delay line, with its bind.
// Depends on modulated_fractional_delay_line_core.
module mfdl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [15:0]       rsp_tdata
);

   logic [1:0] pending_ff, pending_in;

   // Track items accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff + 2'd1;
      end else if (!(req_tvalid && req_tready) && rsp_tvalid && rsp_tready) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // No result left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // One item at a time is taken into the sequencer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // Every result belongs to an accepted item
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("result without an accepted item");

   // At most one item in work and one waiting in the output register
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many items outstanding");

endmodule

bind modulated_fractional_delay_line_core mfdl_checker u_mfdl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: test/tb_modulated_fractional_delay_line_core.sv
// Testbench for modulated_fractional_delay_line_core: streams audio and modulation items,
// predicts every delayed sample and checks each result in order.
// Depends on mfdl_pkg and the core RTL; self-contained otherwise.
module tb_modulated_fractional_delay_line_core;
   timeunit 1ns;
   timeprecision 1ps;
   import mfdl_pkg::*;

   localparam int DEPTH = MFDL_STORE_DEPTH;
   localparam int FB    = MFDL_FRACTION_BITS;

   // Tracks the delay history and holds the samples still owed by the core
   class delay_line_tracker;
      bit [SAMPLE_W-1:0] history [DEPTH];
      int unsigned       write_ptr;
      bit [BASE_W-1:0]   base_delay;
      bit [SAMPLE_W-1:0] owed_samples [$];
      int unsigned       seen;
      int unsigned       errors;

      function new();
         write_ptr  = 0;
         base_delay = BASE_DELAY_RESET;
         seen       = 0;
         errors     = 0;
      endfunction

      function void set_base(bit [BASE_W-1:0] value);
         base_delay = value;
      endfunction

      function int unsigned pending();
         return owed_samples.size();
      endfunction

      // Store the sample, then blend the two taps around the modulated delay
      function void note_item(bit [SAMPLE_W-1:0] smp, bit [SAMPLE_W-1:0] modv);
         longint      w;
         longint      m;
         longint      d;
         longint      dmax;
         longint      f;
         longint      a;
         longint      b;
         longint      acc;
         longint      r;
         int unsigned n;
         int unsigned tap_a;
         int unsigned tap_b;
         w    = longint'(1) << FB;
         m    = longint'({~modv[15], modv[14:0]});
         d    = (longint'(base_delay) * m) >>> 16;
         dmax = longint'(DEPTH - 1) * w - 1;
         if (d > dmax) d = dmax;
         n = int'(d >>> FB);
         f = d & (w - 1);
         history[write_ptr] = smp;
         tap_a = (write_ptr + DEPTH - n) % DEPTH;
         tap_b = (write_ptr + DEPTH - n - 1) % DEPTH;
         a     = longint'($signed(history[tap_a]));
         b     = longint'($signed(history[tap_b]));
         acc   = a * (w - f) + b * f;
         r     = (acc + (w >>> 1)) >>> FB;
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         owed_samples.push_back(r[SAMPLE_W-1:0]);
         write_ptr = (write_ptr + 1) % DEPTH;
      endfunction

      task report(string msg);
         errors++;
         // cap the log, keep counting
         if (errors <= 60) $display("ERROR: result %0d: %s", seen, msg);
      endtask

      // Compare one result with the oldest owed sample
      task check_result(logic [SAMPLE_W-1:0] got);
         bit [SAMPLE_W-1:0] want;
         if (owed_samples.size() == 0) begin
            report($sformatf("unexpected result %0d", $signed(got)));
         end else begin
            want = owed_samples.pop_front();
            if (got !== want)
               report($sformatf("sample_out got %0d want %0d", $signed(got), $signed(want)));
         end
         seen++;
      endtask
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;   // [15:0] sample_in, [31:16] mod_in
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [15:0]       rsp_tdata;         // [15:0] sample_out
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [BASE_W-1:0] csr_wdata  = '0;   // base_delay_q8

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   delay_line_tracker dline = new();

   modulated_fractional_delay_line_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Watch every handshake
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) dline.set_base(csr_wdata);
         if (req_tvalid && req_tready) dline.note_item(req_tdata[15:0], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready) dline.check_result(rsp_tdata);
      end
   end

   // Offer one item after a random gap; valid stays high for the next item
   task automatic send_item(input logic [15:0] smp, input logic [15:0] modv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {modv, smp};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the sender until every owed sample has come back, then let the core settle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (dline.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly random, sometimes an extreme
   function automatic logic [15:0] pick_field();
      case ($urandom_range(19))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [BASE_W-1:0] pick_base(input int unsigned p);
      case (p)
         2:       return {BASE_W{1'b1}};
         4:       return BASE_W'($urandom);
         6:       return BASE_DELAY_RESET;
         default: return BASE_W'($urandom_range(64 * 256));
      endcase
   endfunction

   // Give up if the core hangs
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset delay: mod_in of 0x8000 scales the delay to zero and echoes the sample just written
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h8000);
      send_item(16'h0001, 16'h8000);
      send_item(16'hFFFF, 16'h7FFF);
      send_item(16'h0000, 16'h0000);

      // Longest base delay, full modulation
      write_base({BASE_W{1'b1}});
      send_item(16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h8000);
      send_item(16'h1234, 16'h0000);
      send_item(16'hEDCB, 16'h7FFF);

      // No delay at all
      write_base('0);
      send_item(16'h8000, 16'h7FFF);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h5A5A, 16'h3039);

      // Base delay of one and a half samples: blend between extremes
      write_base(BASE_W'(384));
      send_item(16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h7FFF);
      send_item(16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h0000);
      send_item(16'h7FFF, 16'h8000);
      send_item(16'h8000, 16'h4000);
      send_item(16'hFFFF, 16'hC000);
      send_item(16'h0001, 16'h7FFF);

      // Random phases: every idling mix, several base delays
      for (int unsigned p = 0; p < 8; p++) begin
         write_base(pick_base(p));
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 51; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 51; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         for (int i = 0; i < 191; i++) begin
            if (i == 95) settle();
            send_item(pick_field(), pick_field());
         end
      end

      settle();
      if (dline.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
